[sv/zcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// zcd_pkg: shared types, codes and the fixed-field layout table of the
// zip central directory parser; no dependencies

package zcd_pkg;

	localparam logic [31:0] CDH_SIGNATURE = 32'h0201_4b50;

	localparam logic [4:0] KIND_NAME    = 5'd16;
	localparam logic [4:0] KIND_EXTRA   = 5'd17;
	localparam logic [4:0] KIND_COMMENT = 5'd18;
	localparam logic [4:0] KIND_STATUS  = 5'd19;

	localparam logic [1:0] ST_CONT  = 2'd0;
	localparam logic [1:0] ST_END   = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [3:0] FLD_NAME_LEN    = 4'd9;
	localparam logic [3:0] FLD_EXTRA_LEN   = 4'd10;
	localparam logic [3:0] FLD_COMMENT_LEN = 4'd11;
	localparam logic [3:0] FLD_LAST        = 4'd15;

	typedef enum logic [2:0] {
		PH_SIG     = 3'd0,
		PH_FIXED   = 3'd1,
		PH_NAME    = 3'd2,
		PH_EXTRA   = 3'd3,
		PH_COMMENT = 3'd4,
		PH_STOP    = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic        emit;
		logic [4:0]  item_kind;
		logic [31:0] item_value;
		logic        header_done;
		logic [1:0]  stream_status;
	} result_t;

	typedef struct packed {
		logic [3:0] field;
		logic [1:0] offset;
		logic       last;
	} fld_info_t;

	// field number, byte offset in field and last-byte flag for a header position
	function automatic fld_info_t fld_lookup(input logic [5:0] pos);
		fld_info_t  fi;
		logic [5:0] p;
		logic [5:0] start;
		logic [5:0] fend;
		begin
			p = (pos < 6'd4 || pos > 6'd45) ? 6'd45 : pos;
			case (p) inside
				[6'd4:6'd5]:   begin fi.field = 4'd0;  start = 6'd4;  fend = 6'd6;  end
				[6'd6:6'd7]:   begin fi.field = 4'd1;  start = 6'd6;  fend = 6'd8;  end
				[6'd8:6'd9]:   begin fi.field = 4'd2;  start = 6'd8;  fend = 6'd10; end
				[6'd10:6'd11]: begin fi.field = 4'd3;  start = 6'd10; fend = 6'd12; end
				[6'd12:6'd13]: begin fi.field = 4'd4;  start = 6'd12; fend = 6'd14; end
				[6'd14:6'd15]: begin fi.field = 4'd5;  start = 6'd14; fend = 6'd16; end
				[6'd16:6'd19]: begin fi.field = 4'd6;  start = 6'd16; fend = 6'd20; end
				[6'd20:6'd23]: begin fi.field = 4'd7;  start = 6'd20; fend = 6'd24; end
				[6'd24:6'd27]: begin fi.field = 4'd8;  start = 6'd24; fend = 6'd28; end
				[6'd28:6'd29]: begin fi.field = 4'd9;  start = 6'd28; fend = 6'd30; end
				[6'd30:6'd31]: begin fi.field = 4'd10; start = 6'd30; fend = 6'd32; end
				[6'd32:6'd33]: begin fi.field = 4'd11; start = 6'd32; fend = 6'd34; end
				[6'd34:6'd35]: begin fi.field = 4'd12; start = 6'd34; fend = 6'd36; end
				[6'd36:6'd37]: begin fi.field = 4'd13; start = 6'd36; fend = 6'd38; end
				[6'd38:6'd41]: begin fi.field = 4'd14; start = 6'd38; fend = 6'd42; end
				default:       begin fi.field = 4'd15; start = 6'd42; fend = 6'd46; end
			endcase
			fi.offset = 2'(p - start);
			fi.last   = ((p + 6'd1) == fend);
			return fi;
		end
	endfunction

endpackage

`default_nettype wire

[sv/zcd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// zcd_in_if: byte stream channel into the parser
// no dependencies

interface zcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

`default_nettype wire

[sv/zcd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// zcd_out_if: parsed item channel out of the parser
// no dependencies

interface zcd_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  item_kind;
	logic [31:0] item_value;
	logic        header_done;
	logic [1:0]  stream_status;

	modport source (output valid, output item_kind, output item_value,
		output header_done, output stream_status, input ready);
	modport sink (input valid, input item_kind, input item_value,
		input header_done, input stream_status, output ready);
endinterface

`default_nettype wire

[sv/zcd_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// zcd_in_stage: input register for the byte stream
// depends on zcd_pkg and zcd_in_if

module zcd_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	zcd_in_if.sink               dir_stream,
	input  wire logic            advance,
	output logic                 item_valid,
	output zcd_pkg::in_item_t    item
);

	logic              valid_s1;
	zcd_pkg::in_item_t item_s1;

	assign dir_stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (dir_stream.ready) begin
			valid_s1 <= dir_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dir_stream.ready && dir_stream.valid) begin
			item_s1.data_byte   <= dir_stream.data_byte;
			item_s1.end_of_data <= dir_stream.end_of_data;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

`default_nettype wire

[sv/zcd_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// zcd_parser: header state and one-byte step of the parse
// depends on zcd_pkg

module zcd_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire zcd_pkg::in_item_t  item,
	output zcd_pkg::result_t        res
);

	zcd_pkg::phase_t phase_q, phase_n;
	logic [5:0]      pos_q, pos_n;
	logic [31:0]     acc_q, acc_n;
	logic [15:0]     name_len_q, name_len_n;
	logic [15:0]     extra_len_q, extra_len_n;
	logic [15:0]     cmt_len_q, cmt_len_n;
	logic [15:0]     remain_q, remain_n;

	zcd_pkg::fld_info_t fi;
	logic [31:0]        acc_sig;
	logic [31:0]        acc_fld;
	logic [15:0]        remain_dec;
	logic               hdr_end;

	assign fi         = zcd_pkg::fld_lookup(pos_q);
	assign acc_sig    = acc_q | (32'(item.data_byte) << {pos_q[1:0], 3'b000});
	assign acc_fld    = acc_q | (32'(item.data_byte) << {fi.offset, 3'b000});
	assign remain_dec = remain_q - 16'd1;

	// next state
	always_comb begin
		phase_n     = phase_q;
		pos_n       = pos_q;
		acc_n       = acc_q;
		name_len_n  = name_len_q;
		extra_len_n = extra_len_q;
		cmt_len_n   = cmt_len_q;
		remain_n    = remain_q;
		hdr_end     = 1'b0;
		case (phase_q)
			zcd_pkg::PH_SIG: begin
				acc_n = acc_sig;
				pos_n = {4'b0000, pos_q[1:0]} + 6'd1;
				if (pos_q[1:0] == 2'd3) begin
					acc_n = '0;
					if (acc_sig != zcd_pkg::CDH_SIGNATURE) begin
						phase_n = zcd_pkg::PH_STOP;
					end else begin
						phase_n = zcd_pkg::PH_FIXED;
					end
				end
			end
			zcd_pkg::PH_FIXED: begin
				acc_n = acc_fld;
				pos_n = pos_q + 6'd1;
				if (fi.last) begin
					acc_n = '0;
					case (fi.field)
						zcd_pkg::FLD_NAME_LEN:    name_len_n  = acc_fld[15:0];
						zcd_pkg::FLD_EXTRA_LEN:   extra_len_n = acc_fld[15:0];
						zcd_pkg::FLD_COMMENT_LEN: cmt_len_n   = acc_fld[15:0];
						zcd_pkg::FLD_LAST: begin
							if (name_len_q != '0) begin
								phase_n  = zcd_pkg::PH_NAME;
								remain_n = name_len_q;
							end else if (extra_len_q != '0) begin
								phase_n  = zcd_pkg::PH_EXTRA;
								remain_n = extra_len_q;
							end else if (cmt_len_q != '0) begin
								phase_n  = zcd_pkg::PH_COMMENT;
								remain_n = cmt_len_q;
							end else begin
								hdr_end = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			zcd_pkg::PH_NAME: begin
				remain_n = remain_dec;
				if (remain_dec == '0) begin
					if (extra_len_q != '0) begin
						phase_n  = zcd_pkg::PH_EXTRA;
						remain_n = extra_len_q;
					end else if (cmt_len_q != '0) begin
						phase_n  = zcd_pkg::PH_COMMENT;
						remain_n = cmt_len_q;
					end else begin
						hdr_end = 1'b1;
					end
				end
			end
			zcd_pkg::PH_EXTRA: begin
				remain_n = remain_dec;
				if (remain_dec == '0) begin
					if (cmt_len_q != '0) begin
						phase_n  = zcd_pkg::PH_COMMENT;
						remain_n = cmt_len_q;
					end else begin
						hdr_end = 1'b1;
					end
				end
			end
			zcd_pkg::PH_COMMENT: begin
				remain_n = remain_dec;
				if (remain_dec == '0) begin
					hdr_end = 1'b1;
				end
			end
			zcd_pkg::PH_STOP: ;
			default: phase_n = zcd_pkg::PH_STOP;
		endcase
		if (hdr_end) begin
			phase_n  = zcd_pkg::PH_SIG;
			pos_n    = '0;
			acc_n    = '0;
			remain_n = '0;
		end
		if (item.end_of_data) begin
			phase_n     = zcd_pkg::PH_SIG;
			pos_n       = '0;
			acc_n       = '0;
			name_len_n  = '0;
			extra_len_n = '0;
			cmt_len_n   = '0;
			remain_n    = '0;
		end
	end

	// result of this byte
	always_comb begin
		res.emit          = 1'b0;
		res.item_kind     = zcd_pkg::KIND_STATUS;
		res.item_value    = '0;
		res.header_done   = hdr_end;
		res.stream_status = zcd_pkg::ST_CONT;
		case (phase_q)
			zcd_pkg::PH_SIG: begin
				if (pos_q[1:0] == 2'd3 && acc_sig != zcd_pkg::CDH_SIGNATURE) begin
					res.emit          = 1'b1;
					res.stream_status = zcd_pkg::ST_BAD;
				end
			end
			zcd_pkg::PH_FIXED: begin
				if (fi.last) begin
					res.emit       = 1'b1;
					res.item_kind  = {1'b0, fi.field};
					res.item_value = acc_fld;
				end
			end
			zcd_pkg::PH_NAME: begin
				res.emit       = 1'b1;
				res.item_kind  = zcd_pkg::KIND_NAME;
				res.item_value = 32'(item.data_byte);
			end
			zcd_pkg::PH_EXTRA: begin
				res.emit       = 1'b1;
				res.item_kind  = zcd_pkg::KIND_EXTRA;
				res.item_value = 32'(item.data_byte);
			end
			zcd_pkg::PH_COMMENT: begin
				res.emit       = 1'b1;
				res.item_kind  = zcd_pkg::KIND_COMMENT;
				res.item_value = 32'(item.data_byte);
			end
			default: ;
		endcase
		if (item.end_of_data) begin
			if (phase_q == zcd_pkg::PH_STOP) begin
				res.emit = 1'b0;
			end else if (res.stream_status != zcd_pkg::ST_BAD) begin
				res.emit          = 1'b1;
				res.stream_status = hdr_end ? zcd_pkg::ST_END : zcd_pkg::ST_TRUNC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= zcd_pkg::PH_SIG;
			pos_q       <= '0;
			acc_q       <= '0;
			name_len_q  <= '0;
			extra_len_q <= '0;
			cmt_len_q   <= '0;
			remain_q    <= '0;
		end else if (step) begin
			phase_q     <= phase_n;
			pos_q       <= pos_n;
			acc_q       <= acc_n;
			name_len_q  <= name_len_n;
			extra_len_q <= extra_len_n;
			cmt_len_q   <= cmt_len_n;
			remain_q    <= remain_n;
		end
	end

	a_eod_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.end_of_data |=> phase_q == zcd_pkg::PH_SIG && pos_q == '0 && acc_q == '0)
		else $error("state not cleared after end of data");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.header_done |-> res.emit)
		else $error("header end without an item");

	a_bad_from_sig: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.emit && res.stream_status == zcd_pkg::ST_BAD |->
			phase_q == zcd_pkg::PH_SIG && pos_q[1:0] == 2'd3)
		else $error("bad signature status outside signature check");

endmodule

`default_nettype wire

[sv/zcd_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// zcd_out_stage: result register toward the item channel
// depends on zcd_pkg and zcd_out_if

module zcd_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire zcd_pkg::result_t   res,
	zcd_out_if.source               parsed,
	output logic                    free
);

	logic        valid_q;
	logic [4:0]  kind_q;
	logic [31:0] value_q;
	logic        done_q;
	logic [1:0]  status_q;

	assign free = !valid_q || parsed.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= res.emit;
		end else if (parsed.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.emit) begin
			kind_q   <= res.item_kind;
			value_q  <= res.item_value;
			done_q   <= res.header_done;
			status_q <= res.stream_status;
		end
	end

	assign parsed.valid         = valid_q;
	assign parsed.item_kind     = kind_q;
	assign parsed.item_value    = value_q;
	assign parsed.header_done   = done_q;
	assign parsed.stream_status = status_q;

	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_q == $past(res.emit))
		else $error("result register out of step with parser");

endmodule

`default_nettype wire

[sv/zip_central_directory_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// Parses a zip central directory arriving one byte per request on dir_stream and
// emits each fixed header field, each name, extra and comment byte, and status items
// on parsed. One byte is taken every cycle when the result side keeps up; a byte
// passes an input register and the header step logic into the result register,
// from which its item is shown on parsed. Bytes that give no item (signature bytes,
// non-final field bytes, bytes after a bad signature) are still taken and stepped
// through the parser like the rest. No clearing pass after reset.
// depends on zcd_pkg, zcd_in_if, zcd_out_if, zcd_in_stage, zcd_parser, zcd_out_stage

module zip_central_directory_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	zcd_in_if.sink    dir_stream,
	zcd_out_if.source parsed
);

	logic              item_valid;
	zcd_pkg::in_item_t item;
	zcd_pkg::result_t  res;
	logic              free;
	logic              take;

	assign take = item_valid && free;

	zcd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.dir_stream (dir_stream),
		.advance    (take),
		.item_valid (item_valid),
		.item       (item)
	);

	zcd_parser u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (take),
		.item   (item),
		.res    (res)
	);

	zcd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.res    (res),
		.parsed (parsed),
		.free   (free)
	);

endmodule

`default_nettype wire
